// ===== rtl/polyline_mean_curvature_assert.svh =====
// Assertion macros used by the RTL of the curvature block.
`ifndef POLYLINE_MEAN_CURVATURE_ASSERT_SVH
`define POLYLINE_MEAN_CURVATURE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the polyline curvature block.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int COORD_W   = 32;  // Q16.16 coordinate
  localparam int MAG_W     = 32;  // tangent component magnitude after scaling
  localparam int SEG_LEN_W = 16;  // segment_length register
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SEG_LEN   = 2'd0;
  localparam cfg_idx_t CFG_MIN_START = 2'd1;
  localparam cfg_idx_t CFG_MAX_START = 2'd2;

  // handshake of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/pmc_serial_sqrt.sv =====
// ----------------------------------------------------------------------------
// pmc_serial_sqrt
// Digit-by-digit integer square root, one base-4 digit per cycle.
// ----------------------------------------------------------------------------
module pmc_serial_sqrt import pmc_pkg::*; #(
  parameter int RAD_W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     rad,
  output unit_stat_t           stat,
  output logic [RAD_W/2-1:0]   root,
  output logic [RAD_W/2:0]     rem
);

  localparam int STEPS = RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] r;
  logic [RAD_W-1:0] bitm;
  logic [RAD_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign trial = r + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= rad;
        r    <= '0;
        bitm <= RAD_W'(1) << (RAD_W - 2);
        cnt  <= CNT_W'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder is rad - root^2, never above 2*root
  assign root      = r[RAD_W/2-1:0];
  assign rem       = v[RAD_W/2:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/pmc_serial_div.sv =====
// ----------------------------------------------------------------------------
// pmc_serial_div
// Restoring divider, one quotient bit per cycle. The numerator bits above
// the quotient field must already be below the divisor.
// ----------------------------------------------------------------------------
module pmc_serial_div import pmc_pkg::*; #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output unit_stat_t       stat,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] nsh;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   sh;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign sh = {rem, nsh[QUO_W-1]};
  assign ge = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= DEN_W'(num >> QUO_W);
        nsh  <= num[QUO_W-1:0];
        dreg <= den;
        quo  <= '0;
        cnt  <= CNT_W'(QUO_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? DEN_W'(sh - {1'b0, dreg}) : DEN_W'(sh);
        nsh  <= nsh << 1;
        quo  <= {quo[QUO_W-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/polyline_mean_curvature.sv =====
// ----------------------------------------------------------------------------
// polyline_mean_curvature
// Streamline curvature: unit tangent difference per point, segment means,
// running min and max. Square roots and divisions run bit-serially.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  cfg      | cfg_we                       | cfg_index, cfg_data
//  in       | in_valid / in_ready          | point_x/y/z, last_point
//  out      | out_valid / out_ready        | curvature, segment and min/max
//
//  The first point of a segment skips the roots and divides. Later points use
//  the root unit twice (tangent length, then curvature) and the tangent divide;
//  the second point skips the curvature root, a zero-length tangent skips the
//  divide. Closing a segment of three or more points adds the mean divide.
//  One item is worked on at a time; the output register lets the next item
//  in while a result waits. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module polyline_mean_curvature import pmc_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int FRAC_BITS  = 16,
  localparam int CURV_W    = FRAC_BITS + 2,
  localparam int CFG_W     = (CURV_W > SEG_LEN_W) ? CURV_W : SEG_LEN_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  cfg_idx_t                  cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CURV_W-1:0]         local_curvature,
  output logic                      local_valid,
  output logic [CURV_W-1:0]         segment_mean,
  output logic                      segment_done,
  output logic [INDEX_BITS-1:0]     segment_first,
  output logic [INDEX_BITS-1:0]     segment_points,
  output logic [CURV_W-1:0]         running_min,
  output logic [CURV_W-1:0]         running_max,
  output logic                      stream_done
);

  `include "polyline_mean_curvature_assert.svh"

  localparam int RAD_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int DNUM_W = MAG_W + FRAC_BITS;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int SUM_W  = CURV_W + INDEX_BITS;
  localparam int LEN_W  = (INDEX_BITS > SEG_LEN_W) ? INDEX_BITS : SEG_LEN_W;
  localparam logic [CURV_W-1:0] ONE_Q    = CURV_W'(1) << FRAC_BITS;
  localparam logic [CURV_W-1:0] CURV_MAX = CURV_W'(2) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SQ1, S_RT1S, S_RT1, S_DIVS, S_DIVW, S_TAN,
    S_SQ2, S_RT2S, S_RT2, S_FIN, S_MEANS, S_MEANW, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [SEG_LEN_W-1:0] seg_len;
  logic [CURV_W-1:0]    min_start;
  logic [CURV_W-1:0]    max_start;

  // block state
  logic signed [COORD_W-1:0] prev_pt [3];
  logic signed [CURV_W-1:0]  prev_t  [3];
  logic [INDEX_BITS-1:0]     pts;
  logic [INDEX_BITS-1:0]     seg_start;
  logic [SUM_W-1:0]          csum;
  logic [CURV_W-1:0]         mn;
  logic [CURV_W-1:0]         mx;

  // item working registers
  logic signed [COORD_W-1:0] cur_pt [3];
  logic                      last_r;
  logic [MAG_W-1:0]          mag    [3];
  logic                      neg    [3];
  logic signed [CURV_W-1:0]  t      [3];
  logic [RAD_W-1:0]          s_acc;
  logic [RAD_W-1:0]          prod;
  logic [1:0]                sq_cnt;
  logic [ROOT_W-1:0]         len;
  logic [CURV_W-1:0]         k;
  logic                      valid_r;
  logic [INDEX_BITS-1:0]     count_r;
  logic                      close_r;
  logic [CURV_W-1:0]         mean_r;

  // combinational
  logic signed [COORD_W:0] dif  [3];
  logic [COORD_W:0]        dabs [3];
  logic                    big;
  logic signed [CURV_W:0]  tdif [3];
  logic [CURV_W:0]         tabs [3];
  logic [MAG_W-1:0]        mul_a;
  logic [INDEX_BITS-1:0]   count_n;
  logic                    close_n;
  logic [ROOT_W:0]         kr;
  logic [INDEX_BITS-1:0]   mdiv;
  logic                    out_free;
  logic                    emit_go;

  // shared root unit
  logic              sq_start;
  unit_stat_t        sq_stat;
  logic [ROOT_W-1:0] sq_root;
  logic [ROOT_W:0]   sq_rem;

  // tangent lanes and mean divider
  logic             div_start;
  unit_stat_t       div_stat [3];
  logic [Q_W-1:0]   div_q    [3];
  logic             mdiv_start;
  unit_stat_t       mdiv_stat;
  logic [CURV_W-1:0] mdiv_q;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dif[i]  = {cur_pt[i][COORD_W-1], cur_pt[i]} - {prev_pt[i][COORD_W-1], prev_pt[i]};
      dabs[i] = dif[i][COORD_W] ? (COORD_W+1)'(-dif[i]) : (COORD_W+1)'(dif[i]);
      big     = big | (|dabs[i][COORD_W:COORD_W-1]);
      tdif[i] = {t[i][CURV_W-1], t[i]} - {prev_t[i][CURV_W-1], prev_t[i]};
      tabs[i] = tdif[i][CURV_W] ? (CURV_W+1)'(-tdif[i]) : (CURV_W+1)'(tdif[i]);
    end
  end

  always_comb begin
    mul_a = '0;
    case (sq_cnt)
      2'd0: mul_a = (state == S_SQ1) ? mag[0] : MAG_W'(tabs[0]);
      2'd1: mul_a = (state == S_SQ1) ? mag[1] : MAG_W'(tabs[1]);
      2'd2: mul_a = (state == S_SQ1) ? mag[2] : MAG_W'(tabs[2]);
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_a;
  end

  assign count_n  = (pts != {INDEX_BITS{1'b1}}) ? pts + INDEX_BITS'(1) : pts;
  assign close_n  = last_r ||
                    (seg_len != '0 && LEN_W'(count_n) == LEN_W'(seg_len));
  assign kr       = {1'b0, sq_root} + (ROOT_W+1)'(sq_rem > {1'b0, sq_root});
  assign mdiv     = count_r - INDEX_BITS'(2);
  assign out_free = !out_valid || out_ready;
  assign emit_go  = (state == S_EMIT) && (valid_r || close_r) && out_free;
  assign in_ready = (state == S_IDLE);

  assign sq_start   = (state == S_RT1S) || (state == S_RT2S);
  assign div_start  = (state == S_DIVS);
  assign mdiv_start = (state == S_MEANS);

  pmc_serial_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .rad  (s_acc),
    .stat (sq_stat),
    .root (sq_root),
    .rem  (sq_rem)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pmc_serial_div #(.NUM_W(DNUM_W), .DEN_W(ROOT_W), .QUO_W(Q_W)) u_div (
      .clk  (clk),
      .rst  (rst),
      .start(div_start),
      .num  ((DNUM_W'(mag[g]) << FRAC_BITS) + DNUM_W'(len >> 1)),
      .den  (len),
      .stat (div_stat[g]),
      .quo  (div_q[g])
    );
  end

  pmc_serial_div #(.NUM_W(SUM_W), .DEN_W(INDEX_BITS), .QUO_W(CURV_W)) u_mdiv (
    .clk  (clk),
    .rst  (rst),
    .start(mdiv_start),
    .num  (csum + SUM_W'(mdiv >> 1)),
    .den  (mdiv),
    .stat (mdiv_stat),
    .quo  (mdiv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_len   <= '0;
      min_start <= CURV_W'(1) << (FRAC_BITS + 1);
      max_start <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_pt[i] <= '0;
        prev_t[i]  <= '0;
      end
      pts       <= '0;
      seg_start <= '0;
      csum      <= '0;
      mn        <= CURV_W'(1) << (FRAC_BITS + 1);
      mx        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEG_LEN:   seg_len   <= SEG_LEN_W'(cfg_data);
          CFG_MIN_START: min_start <= CURV_W'(cfg_data);
          CFG_MAX_START: max_start <= CURV_W'(cfg_data);
          default: ;
        endcase
      end
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_pt[0] <= point_x;
            cur_pt[1] <= point_y;
            cur_pt[2] <= point_z;
            last_r    <= last_point;
            valid_r   <= 1'b0;
            k         <= '0;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) begin
            neg[i]     <= dif[i][COORD_W];
            mag[i]     <= big ? dabs[i][COORD_W:1] : dabs[i][COORD_W-1:0];
            prev_pt[i] <= cur_pt[i];
          end
          s_acc  <= '0;
          sq_cnt <= '0;
          state  <= (pts == '0) ? S_FIN : S_SQ1;
        end
        S_SQ1, S_SQ2: begin
          // product of the previous cycle lands here
          if (sq_cnt != 2'd0) s_acc <= s_acc + prod;
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) state <= (state == S_SQ1) ? S_RT1S : S_RT2S;
        end
        S_RT1S: state <= S_RT1;
        S_RT1: begin
          if (sq_stat.done) begin
            len <= sq_root;
            if (sq_root == '0) begin
              for (int i = 0; i < 3; i++) t[i] <= '0;
              state <= S_TAN;
            end else begin
              state <= S_DIVS;
            end
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_stat[0].done) begin
            for (int i = 0; i < 3; i++) begin
              if (CURV_W'(div_q[i]) > ONE_Q) t[i] <= neg[i] ? -ONE_Q : ONE_Q;
              else t[i] <= neg[i] ? -CURV_W'(div_q[i]) : CURV_W'(div_q[i]);
            end
            state <= S_TAN;
          end
        end
        S_TAN: begin
          s_acc  <= '0;
          sq_cnt <= '0;
          if (pts >= INDEX_BITS'(2)) begin
            state <= S_SQ2;
          end else begin
            for (int i = 0; i < 3; i++) prev_t[i] <= t[i];
            state <= S_FIN;
          end
        end
        S_RT2S: state <= S_RT2;
        S_RT2: begin
          if (sq_stat.done) begin
            // round to nearest: remainder above root means the upper half
            if (kr > (ROOT_W+1)'(CURV_MAX)) begin
              k    <= CURV_MAX;
              csum <= csum + SUM_W'(CURV_MAX);
              if (CURV_MAX < mn) mn <= CURV_MAX;
              if (CURV_MAX > mx) mx <= CURV_MAX;
            end else begin
              k    <= CURV_W'(kr);
              csum <= csum + SUM_W'(kr);
              if (CURV_W'(kr) < mn) mn <= CURV_W'(kr);
              if (CURV_W'(kr) > mx) mx <= CURV_W'(kr);
            end
            valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) prev_t[i] <= t[i];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          pts     <= count_n;
          count_r <= count_n;
          close_r <= close_n;
          mean_r  <= '0;
          state   <= (close_n && count_n >= INDEX_BITS'(3)) ? S_MEANS : S_EMIT;
        end
        S_MEANS: state <= S_MEANW;
        S_MEANW: begin
          if (mdiv_stat.done) begin
            mean_r <= mdiv_q;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!(valid_r || close_r)) begin
            state <= S_IDLE;
          end else if (out_free) begin
            local_curvature <= k;
            local_valid     <= valid_r;
            segment_mean    <= close_r ? mean_r : '0;
            segment_done    <= close_r;
            segment_first   <= close_r ? seg_start : '0;
            segment_points  <= close_r ? count_r : '0;
            running_min     <= mn;
            running_max     <= mx;
            stream_done     <= last_r;
            if (close_r) begin
              seg_start <= last_r ? '0 : seg_start + count_r;
              pts       <= '0;
              csum      <= '0;
              if (last_r) begin
                mn <= min_start;
                mx <= max_start;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PMC_ASSERT_NOW(a_sqrt_free, sq_start, !sq_stat.busy, "root unit restarted while busy")
  `PMC_ASSERT_NOW(a_curv_cap, valid_r && state == S_EMIT, k <= CURV_MAX,
                  "local curvature above cap")
  `PMC_ASSERT_NEXT(a_close_clears,
                   state == S_EMIT && close_r && out_free,
                   pts == '0 && csum == '0, "segment close left count or sum")

endmodule

// ===== bench/tb_polyline_mean_curvature.sv =====
// ----------------------------------------------------------------------------
// tb_polyline_mean_curvature
// Streams points into the curvature block under several register settings and
// idle patterns, predicts every result in the bench and compares each whole
// result in arrival order.
// ----------------------------------------------------------------------------
module tb_polyline_mean_curvature;
  import pmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = 16;
  localparam int FRAC = 16;
  localparam int CURV_W = FRAC + 2;
  localparam int CFG_W = 18;
  localparam longint ONE_Q = 64'd1 << FRAC;
  localparam longint CURV_CAP = 64'd2 << FRAC;
  localparam longint IDX_MAX = (64'd1 << IDX_W) - 1;

  typedef struct packed {
    logic [CURV_W-1:0] curv;
    logic              curv_ok;
    logic [CURV_W-1:0] mean;
    logic              seg_done;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  npts;
    logic [CURV_W-1:0] rmin;
    logic [CURV_W-1:0] rmax;
    logic              strm_done;
  } curv_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SEG_LEN;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CURV_W-1:0] local_curvature, segment_mean, running_min, running_max;
  logic local_valid, segment_done, stream_done;
  logic [IDX_W-1:0] segment_first, segment_points;

  polyline_mean_curvature #(.INDEX_BITS(IDX_W), .FRAC_BITS(FRAC)) i_dut (.*);

  // predictor state
  longint seg_len_r, min_start_r, max_start_r;
  longint prev_pt[3], prev_ut[3];
  longint pts_in_seg, seg_start, curv_sum, min_cur, max_cur;
  curv_res_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off_cycles = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #400ms;
    $display("polyline_mean_curvature: mismatch");
    $finish;
  end

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void unit_dir(input longint a[3], input longint b[3],
                                   output longint u[3]);
    longint m[3];
    bit neg[3];
    bit big = 0;
    longint unsigned s = 0;
    longint len, q;
    for (int i = 0; i < 3; i++) begin
      neg[i] = (b[i] - a[i]) < 0;
      m[i] = neg[i] ? a[i] - b[i] : b[i] - a[i];
      if (m[i] >= (64'd1 << 31)) big = 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (big) m[i] >>= 1;
      s += longint'(m[i]) * longint'(m[i]);
    end
    len = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        q = ((m[i] << FRAC) + len / 2) / len;
        if (q > ONE_Q) q = ONE_Q;
      end
      u[i] = neg[i] ? -q : q;
    end
  endfunction

  function automatic void predict_point(longint x, longint y, longint z, bit last);
    longint p[3], t[3];
    longint k = 0, cnt, mean = 0, pos, r, d;
    longint unsigned s;
    bit ok = 0, close;
    curv_res_t e;
    p[0] = x; p[1] = y; p[2] = z;
    pos = pts_in_seg;
    if (pos >= 1) begin
      unit_dir(prev_pt, p, t);
      if (pos >= 2) begin
        s = 0;
        for (int i = 0; i < 3; i++) begin
          d = t[i] - prev_ut[i];
          s += d * d;
        end
        r = isqrt(s);
        if (s - r * r > r) r++;
        if (r > CURV_CAP) r = CURV_CAP;
        k = r;
        ok = 1;
        curv_sum += k;
        if (k < min_cur) min_cur = k;
        if (k > max_cur) max_cur = k;
      end
      prev_ut = t;
    end
    prev_pt = p;
    cnt = pos < IDX_MAX ? pos + 1 : IDX_MAX;
    pts_in_seg = cnt;
    close = last || (seg_len_r != 0 && cnt == seg_len_r);
    if (close && cnt >= 3) mean = (curv_sum + (cnt - 2) / 2) / (cnt - 2);
    e.curv = CURV_W'(k);
    e.curv_ok = ok;
    e.mean = CURV_W'(close ? mean : 0);
    e.seg_done = close;
    e.first = IDX_W'(close ? seg_start : 0);
    e.npts = IDX_W'(close ? cnt : 0);
    e.rmin = CURV_W'(min_cur);
    e.rmax = CURV_W'(max_cur);
    e.strm_done = last;
    if (close) begin
      seg_start = last ? 0 : ((seg_start + cnt) & IDX_MAX);
      pts_in_seg = 0;
      curv_sum = 0;
      if (last) begin
        min_cur = min_start_r;
        max_cur = max_start_r;
      end
    end
    if (ok || close) expected_q.insert(expected_q.size(), e);
  endfunction

  task automatic write_reg(cfg_idx_t idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SEG_LEN:   seg_len_r = val & 16'hFFFF;
      CFG_MIN_START: min_start_r = val & 18'h3FFFF;
      CFG_MAX_START: max_start_r = val & 18'h3FFFF;
      default: ;
    endcase
  endtask

  // valid stays up after an accept so that items can follow back to back
  task automatic send_point(longint x, longint y, longint z, bit last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    point_x <= 32'(x);
    point_y <= 32'(y);
    point_z <= 32'(z);
    last_point <= last;
    do @(posedge clk); while (!in_ready);
    predict_point(x, y, z, last);
  endtask

  task automatic pause_input;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all results, then let an item with no result drain
  task automatic drain;
    pause_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // receiver: random stall, or a long counted hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    curv_res_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = '{local_curvature, local_valid, segment_mean, segment_done, segment_first,
              segment_points, running_min, running_max, stream_done};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("result differs: exp %p got %p", exp_r, got);
        end
      end
    end
  end

  function automatic longint rnd_coord(longint base);
    case ($urandom_range(5))
      0: return longint'($signed($urandom()));
      1: return $urandom_range(1) ? 64'sh7FFFFFFF : -64'sh80000000;
      2: return base;
      default: return base + $signed($urandom_range(8192)) - 4096 + (($urandom_range(3)==0)
               ? ($signed($urandom_range(2000000)) - 1000000) : 0);
    endcase
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  task automatic send_stream(int n);
    longint x, y, z;
    x = longint'($signed($urandom()));
    y = longint'($signed($urandom()));
    z = longint'($signed($urandom()));
    for (int i = 0; i < n; i++) begin
      x = clip32(rnd_coord(x));
      y = clip32(rnd_coord(y));
      z = clip32(rnd_coord(z));
      send_point(x, y, z, i == n - 1);
    end
  endtask

  task automatic test_directed;
    longint mx = 64'sh7FFFFFFF, mn = -64'sh80000000;
    // extremes, zero-length tangents, reversal
    send_point(0, 0, 0, 0);
    send_point(0, 0, 0, 0);
    send_point(mx, mx, mx, 0);
    send_point(mn, mn, mn, 0);
    send_point(mx, 0, mn, 0);
    send_point(mx, 0, mn, 0);
    send_point(65536, 0, 0, 1);
    // short streams: one and two points
    send_point(5, 5, 5, 1);
    send_point(1, 2, 3, 0);
    send_point(-1, -2, -3, 1);
    // right angle and straight line
    send_point(0, 0, 0, 0);
    send_point(65536, 0, 0, 0);
    send_point(65536, 65536, 0, 0);
    send_point(65536, 131072, 0, 1);
    drain();
  endtask

  task automatic test_segments;
    write_reg(CFG_SEG_LEN, 3);
    write_reg(CFG_MIN_START, 0);
    write_reg(CFG_MAX_START, 131072);
    send_stream(10);
    drain();
    write_reg(CFG_SEG_LEN, 1);
    write_reg(CFG_MIN_START, 131072);
    write_reg(CFG_MAX_START, 0);
    send_stream(5);
    drain();
    // length the counter never reaches
    write_reg(CFG_SEG_LEN, 65535);
    send_stream(6);
    drain();
  endtask

  task automatic test_random(int pct_send, int pct_recv, int n);
    int left = n;
    int len;
    send_idle_pct = pct_send;
    recv_stall_pct = pct_recv;
    write_reg(CFG_SEG_LEN, $urandom_range(3) == 0 ? 0 : $urandom_range(2, 12));
    write_reg(CFG_MIN_START, $urandom_range(131072));
    write_reg(CFG_MAX_START, $urandom_range(131072));
    while (left > 0) begin
      len = $urandom_range(1, 30);
      if (len > left) len = left;
      send_stream(len);
      left -= len;
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_SEG_LEN, 4);
    @(posedge clk);
    hold_off_cycles <= 2000;
    send_stream(12);
    drain();
    // sender waits for every result before going on
    send_stream(5);
    pause_input();
    while (expected_q.size() != 0) @(posedge clk);
    send_stream(5);
    drain();
  endtask

  initial begin
    seg_len_r = 0; min_start_r = 131072; max_start_r = 0;
    prev_pt = '{0, 0, 0}; prev_ut = '{0, 0, 0};
    pts_in_seg = 0; seg_start = 0; curv_sum = 0;
    min_cur = min_start_r; max_cur = max_start_r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_segments();
    test_random(0, 0, 130);
    test_random(75, 0, 110);
    test_random(0, 75, 110);
    test_random(18, 18, 130);
    test_backpressure();
    write_reg(CFG_SEG_LEN, 0);
    if (errors == 0) begin
      $display("polyline_mean_curvature: match");
    end else begin
      $display("polyline_mean_curvature: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pmc_pkg.sv
rtl/pmc_serial_sqrt.sv
rtl/pmc_serial_div.sv
rtl/polyline_mean_curvature.sv
bench/tb_polyline_mean_curvature.sv
